[design/countdown_seven_segment_scanner_macros.svh]
// Assertion macros for the countdown seven-segment scanner.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef COUNTDOWN_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define COUNTDOWN_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cdss_pkg.sv]
// Types and constants for the countdown seven-segment scanner.
// No dependencies.
package cdss_pkg;

  localparam int COUNT_W     = 27;
  localparam int TPS_W       = 16;
  localparam int SEG_W       = 8;
  localparam int DIGIT_IDX_W = 3;
  localparam int SEL_W       = 8;
  localparam int BCD_DIGITS  = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CONV_CNT_W  = $clog2(COUNT_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd1;

  localparam logic [COUNT_W-1:0]      START_RESET     = 27'd1000;
  localparam logic [TPS_W-1:0]        TPS_RESET       = 16'd1000;
  localparam logic [BCD_DIGITS*4-1:0] START_BCD_RESET = 36'h000001000;
  localparam logic [CONV_CNT_W-1:0]   CONV_STEPS      = CONV_CNT_W'(COUNT_W);

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic [DIGIT_IDX_W-1:0] digit_index;
    logic [SEL_W-1:0]       digit_select_n;
    logic [SEG_W-1:0]       segments;
    logic                   second_pulse;
    logic [COUNT_W-1:0]     count_now;
    logic                   at_zero;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] pattern;
    case (digit)
      4'd0:    pattern = 8'h3F;
      4'd1:    pattern = 8'h06;
      4'd2:    pattern = 8'h5B;
      4'd3:    pattern = 8'h4F;
      4'd4:    pattern = 8'h66;
      4'd5:    pattern = 8'h6D;
      4'd6:    pattern = 8'h7D;
      4'd7:    pattern = 8'h07;
      4'd8:    pattern = 8'h7F;
      4'd9:    pattern = 8'h6F;
      default: pattern = SEG_BLANK;
    endcase
    return pattern;
  endfunction

endpackage

[design/countdown_seven_segment_scanner.sv]
// Countdown timer with multiplexed seven-segment scan, one tick per request.
// Depends on cdss_pkg and countdown_seven_segment_scanner_macros.svh.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   restart_i
//   out      output     out_valid_o / out_stall_i digit_index_o .. at_zero_o
//   cfg      input      cfg_we_i                  cfg_addr_i, cfg_data_i
//
// One tick per cycle while the input is not stalled: state and result are
// settled in the accepting cycle and the result goes to the output queue.
// A two-entry output queue keeps taking ticks while one result is stalled.
// A write to start_count runs a shift-add-3 binary-to-decimal conversion;
// the input stalls while it runs.
// After reset the count is 1000, the prescaler is clear and the display blank.
`include "countdown_seven_segment_scanner_macros.svh"

module countdown_seven_segment_scanner
  import cdss_pkg::*;
#(
  parameter int NUM_DIGITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [COUNT_W-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   restart_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DIGIT_IDX_W-1:0] digit_index_o,
  output logic [SEL_W-1:0]       digit_select_n_o,
  output logic [SEG_W-1:0]       segments_o,
  output logic                   second_pulse_o,
  output logic [COUNT_W-1:0]     count_now_o,
  output logic                   at_zero_o
);

  localparam int IDX_W = $clog2(NUM_DIGITS);

  logic [COUNT_W-1:0]    start_count_q;
  logic [TPS_W-1:0]      tps_q;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [TPS_W-1:0]      presc_q, presc_d;
  logic [TPS_W:0]        presc_inc;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [SEG_W-1:0]      seg_buf_q [NUM_DIGITS];
  logic [SEG_W-1:0]      seg_load [NUM_DIGITS];
  logic [3:0]            count_bcd_q [NUM_DIGITS];
  logic [3:0]            count_bcd_dec [NUM_DIGITS];
  logic [3:0]            start_bcd_q [BCD_DIGITS];
  logic                  pulse;
  logic                  in_acc;
  logic                  out_pop;

  logic                  conv_busy_q;
  logic [CONV_CNT_W-1:0] conv_cnt_q;
  logic [COUNT_W-1:0]    conv_bin_q;
  logic [3:0]            conv_bcd_q [BCD_DIGITS];
  logic [3:0]            conv_adj [BCD_DIGITS];
  logic [3:0]            conv_bcd_d [BCD_DIGITS];

  result_t               res_q [2];
  result_t               res_d;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            fifo_cnt_q;

  logic                  borrow;
  logic                  lead;

  assign in_stall_o  = conv_busy_q || (fifo_cnt_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;

  // Shift-add-3 step of the start_count conversion
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      conv_adj[k] = (conv_bcd_q[k] >= 4'd5) ? conv_bcd_q[k] + 4'd3 : conv_bcd_q[k];
    end
    conv_bcd_d[0] = {conv_adj[0][2:0], conv_bin_q[COUNT_W-1]};
    for (int k = 1; k < BCD_DIGITS; k++) begin
      conv_bcd_d[k] = {conv_adj[k][2:0], conv_adj[k-1][3]};
    end
  end

  // Decimal decrement of the shown count and the display pattern
  always_comb begin
    borrow = 1'b1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (borrow) begin
        count_bcd_dec[k] = (count_bcd_q[k] == 4'd0) ? 4'd9 : count_bcd_q[k] - 4'd1;
      end else begin
        count_bcd_dec[k] = count_bcd_q[k];
      end
      borrow = borrow && (count_bcd_q[k] == 4'd0);
    end
    lead = 1'b1;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      lead = lead && (count_bcd_q[NUM_DIGITS-1-p] == 4'd0);
      if (lead && (p < NUM_DIGITS - 1)) begin
        seg_load[p] = SEG_BLANK;
      end else begin
        seg_load[p] = seg_of(count_bcd_q[NUM_DIGITS-1-p]);
      end
    end
  end

  always_comb begin
    presc_inc = {1'b0, presc_q} + (TPS_W+1)'(1);
    pulse     = !restart_i && (presc_inc >= {1'b0, tps_q});
    count_d   = count_q;
    presc_d   = presc_inc[TPS_W-1:0];
    if (restart_i) begin
      count_d = start_count_q;
      presc_d = '0;
    end else if (pulse) begin
      presc_d = '0;
      if (count_q != '0) begin
        count_d = count_q - COUNT_W'(1);
      end
    end
    scan_d = (scan_q == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_q + IDX_W'(1);

    res_d.digit_index    = DIGIT_IDX_W'(scan_q);
    res_d.digit_select_n = ~(SEL_W'(1) << scan_q);
    res_d.segments       = seg_buf_q[scan_q];
    res_d.second_pulse   = pulse;
    res_d.count_now      = count_d;
    res_d.at_zero        = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= START_RESET;
      tps_q         <= TPS_RESET;
      count_q       <= START_RESET;
      presc_q       <= '0;
      scan_q        <= '0;
      conv_busy_q   <= 1'b0;
      conv_cnt_q    <= '0;
      conv_bin_q    <= '0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
        start_bcd_q[k] <= START_BCD_RESET[4*k +: 4];
        conv_bcd_q[k]  <= 4'd0;
      end
      for (int k = 0; k < NUM_DIGITS; k++) begin
        seg_buf_q[k]   <= SEG_BLANK;
        count_bcd_q[k] <= START_BCD_RESET[4*k +: 4];
      end
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_COUNT: begin
            start_count_q <= cfg_data_i;
            conv_bin_q    <= cfg_data_i;
            conv_cnt_q    <= CONV_STEPS;
            conv_busy_q   <= 1'b1;
            for (int k = 0; k < BCD_DIGITS; k++) begin
              conv_bcd_q[k] <= 4'd0;
            end
          end
          CFG_TICKS_PER_SECOND: begin
            tps_q <= cfg_data_i[TPS_W-1:0];
          end
          default: begin
          end
        endcase
      end else if (conv_busy_q) begin
        conv_bin_q <= {conv_bin_q[COUNT_W-2:0], 1'b0};
        conv_cnt_q <= conv_cnt_q - CONV_CNT_W'(1);
        for (int k = 0; k < BCD_DIGITS; k++) begin
          conv_bcd_q[k] <= conv_bcd_d[k];
        end
        if (conv_cnt_q == CONV_CNT_W'(1)) begin
          conv_busy_q <= 1'b0;
          for (int k = 0; k < BCD_DIGITS; k++) begin
            start_bcd_q[k] <= conv_bcd_d[k];
          end
        end
      end

      if (in_acc) begin
        count_q <= count_d;
        presc_q <= presc_d;
        scan_q  <= scan_d;
        if (restart_i) begin
          for (int k = 0; k < NUM_DIGITS; k++) begin
            seg_buf_q[k]   <= SEG_BLANK;
            count_bcd_q[k] <= start_bcd_q[k];
          end
        end else if (pulse) begin
          for (int k = 0; k < NUM_DIGITS; k++) begin
            seg_buf_q[k] <= seg_load[k];
          end
          if (count_q != '0) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
              count_bcd_q[k] <= count_bcd_dec[k];
            end
          end
        end
        res_q[wr_ptr_q] <= res_d;
        wr_ptr_q        <= !wr_ptr_q;
      end

      if (out_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({in_acc, out_pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + 2'd1;
        2'b01:   fifo_cnt_q <= fifo_cnt_q - 2'd1;
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  assign digit_index_o    = res_q[rd_ptr_q].digit_index;
  assign digit_select_n_o = res_q[rd_ptr_q].digit_select_n;
  assign segments_o       = res_q[rd_ptr_q].segments;
  assign second_pulse_o   = res_q[rd_ptr_q].second_pulse;
  assign count_now_o      = res_q[rd_ptr_q].count_now;
  assign at_zero_o        = res_q[rd_ptr_q].at_zero;

  `CDSS_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt_q != 2'd3, "output queue overflow")
  `CDSS_ASSERT_NOW(a_one_cold, out_valid_o, $countones(~digit_select_n_o) == 1, "digit select not one-cold")
  `CDSS_ASSERT_NEXT(a_restart_presc, in_acc && restart_i, presc_q == '0, "prescaler not cleared on restart")
  `CDSS_ASSERT_NEXT(a_zero_hold, in_acc && !restart_i && (count_q == '0), count_q == '0, "count left zero without restart")

endmodule
